/* rtl/equal_partition_breaker_unit_assert.svh */
// Assertion macros for the equal partition breaker RTL.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef EQUAL_PARTITION_BREAKER_UNIT_ASSERT_SVH
`define EQUAL_PARTITION_BREAKER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define EPB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define EPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/epb_pkg.sv */
// Shared constants, command/status structs and a helper function for the
// equal partition breaker. No dependencies.
`default_nettype none

package epb_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int MAX_SUM   = 8192;
    localparam int VALUE_W   = 11;
    localparam int WORD_W    = 64;

    localparam int NUM_WORDS = MAX_SUM / WORD_W;
    localparam int ADDR_W    = $clog2(NUM_WORDS);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int K_W       = ADDR_W + 1;
    localparam int Q_W       = VALUE_W - BIT_W;
    localparam int BADDR_W   = ((K_W > Q_W) ? K_W : Q_W) + 1;
    localparam int TOTAL_W   = $clog2(MAX_SUM + 1);
    localparam int SUM_W     = ((TOTAL_W > VALUE_W) ? TOTAL_W : VALUE_W) + 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 2);
    localparam int TZ_W      = 4;
    localparam int INDEX_W   = 7;

    localparam logic [TZ_W-1:0] TZ_RESET = 4'd15;

    // Controller to datapath.
    typedef struct packed {
        logic           accept;       // take the beat on the item channel
        logic           shift_issue;  // issue one step of the shift-OR sweep
        logic [K_W-1:0] k;            // sweep step, NUM_WORDS down to 0
        logic           query;        // read the word holding half the total
        logic           finish;       // load the result and clear the set
    } epb_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic need_shift;  // the offered item updates the reachable sums
        logic item_last;   // the offered item closes the set
        logic out_free;    // the result register can take a new beat
    } epb_status_t;

    // Count of trailing zeros; zero counts as none.
    function automatic logic [TZ_W-1:0] trailing_zeros(input logic [VALUE_W-1:0] v);
        logic [TZ_W-1:0] n;
        n = '0;
        for (int i = VALUE_W - 1; i >= 0; i--) begin
            if (v[i])
            begin
                n = TZ_W'(i);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* rtl/epb_ctrl.sv */
// Sequencer for the equal partition breaker: accept, sweep, drain, query, finish.
// Depends on epb_pkg and equal_partition_breaker_unit_assert.svh.
`default_nettype none
`include "equal_partition_breaker_unit_assert.svh"

module epb_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire epb_pkg::epb_status_t status,
    output epb_pkg::epb_cmd_t        cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SHIFT  = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_QUERY  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t                      state_reg, state_next;
    logic [epb_pkg::K_W-1:0]     k_reg, k_next;
    logic                        last_reg, last_next;

    assign item_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        last_next       = last_reg;
        cmd             = '0;
        cmd.k           = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    last_next  = status.item_last;
                    if (status.need_shift)
                    begin
                        state_next = ST_SHIFT;
                        k_next     = epb_pkg::K_W'(epb_pkg::NUM_WORDS);
                    end
                    else if (status.item_last)
                    begin
                        state_next = ST_QUERY;
                    end
                end
            end
            ST_SHIFT:
            begin
                cmd.shift_issue = 1'b1;
                if (k_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg - 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // let the write of word zero land
                state_next = last_reg ? ST_QUERY : ST_IDLE;
            end
            ST_QUERY:
            begin
                cmd.query  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            last_reg  <= last_next;
        end
    end

    `EPB_ASSERT_NEXT(a_sweep_ends_in_drain, (state_reg == ST_SHIFT) && (k_reg == '0), state_reg == ST_DRAIN, "sweep did not end in drain")
    `EPB_ASSERT_IMP(a_drain_follows_sweep, state_reg == ST_DRAIN, $past(state_reg) == ST_SHIFT, "drain entered without a sweep")
    `EPB_ASSERT_NEXT(a_finish_returns_idle, (state_reg == ST_FINISH) && status.out_free, state_reg == ST_IDLE, "finish did not return to idle")

endmodule

`default_nettype wire

/* rtl/epb_datapath.sv */
// Datapath: set statistics, reachable-sum word memory with shift-OR stage,
// and the result register. Depends on epb_pkg and the assertion header.
`default_nettype none
`include "equal_partition_breaker_unit_assert.svh"

module epb_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire epb_pkg::epb_cmd_t                 cmd,
    output epb_pkg::epb_status_t                   status,
    input  wire logic [epb_pkg::VALUE_W-1:0]       value,
    input  wire logic                              last,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output logic                                   remove_count,
    output logic [epb_pkg::INDEX_W-1:0]            remove_index,
    output logic                                   overflow
);

    // set statistics
    logic [epb_pkg::CNT_W-1:0]   cnt_reg;
    logic [epb_pkg::TOTAL_W-1:0] total_reg;
    logic [epb_pkg::CNT_W-1:0]   odd_idx_reg;
    logic [epb_pkg::TZ_W-1:0]    fz_reg;
    logic [epb_pkg::CNT_W-1:0]   fz_idx_reg;
    logic                        ovf_reg;
    logic [epb_pkg::VALUE_W-1:0] val_reg;

    logic [epb_pkg::CNT_W-1:0]   cnt_inc;
    logic                        ovf_now;
    logic [epb_pkg::SUM_W-1:0]   sum_c;
    logic                        sum_ovf;
    logic [epb_pkg::TZ_W-1:0]    tz_c;

    // memory and sweep stage
    logic [epb_pkg::WORD_W-1:0]    mem [epb_pkg::NUM_WORDS];
    logic [epb_pkg::NUM_WORDS-1:0] word_valid_reg;
    logic [epb_pkg::WORD_W-1:0]    a_data_reg, b_data_reg, bprev_reg;
    logic                          a_ok_reg, a_zero_reg;
    logic                          b_ok_reg, b_zero_reg, b_neg_reg;
    logic                          s1_act_reg, s1_wr_reg;
    logic [epb_pkg::ADDR_W-1:0]    s1_addr_reg;

    logic                          re_a, re_b;
    logic [epb_pkg::ADDR_W-1:0]    ra_c, rb_c;
    logic [epb_pkg::BADDR_W-1:0]   rb_full;
    logic                          rb_neg;
    logic [epb_pkg::TOTAL_W-2:0]   half_c;
    logic [epb_pkg::Q_W-1:0]       q_c;
    logic [epb_pkg::BIT_W-1:0]     r_c;
    logic [epb_pkg::WORD_W-1:0]    a_eff, b_eff, new_word;
    logic [2*epb_pkg::WORD_W-1:0]  pair_shift;

    // result
    logic                          remove_c;
    logic [epb_pkg::INDEX_W-1:0]   index_c;
    logic                          result_valid_reg;

    // ---------------- statistics ----------------
    assign cnt_inc = (cnt_reg <= epb_pkg::CNT_W'(epb_pkg::MAX_ITEMS)) ? cnt_reg + 1'b1 : cnt_reg;
    assign ovf_now = ovf_reg || (cnt_inc > epb_pkg::CNT_W'(epb_pkg::MAX_ITEMS));
    assign sum_c   = epb_pkg::SUM_W'(total_reg) + epb_pkg::SUM_W'(value);
    assign sum_ovf = (sum_c >= epb_pkg::SUM_W'(epb_pkg::MAX_SUM));
    assign tz_c    = epb_pkg::trailing_zeros(value);

    assign status.need_shift = !ovf_now && !sum_ovf;
    assign status.item_last  = last;
    assign status.out_free   = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            total_reg   <= '0;
            odd_idx_reg <= '0;
            fz_reg      <= epb_pkg::TZ_RESET;
            fz_idx_reg  <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (cmd.finish)
        begin
            cnt_reg     <= '0;
            total_reg   <= '0;
            odd_idx_reg <= '0;
            fz_reg      <= epb_pkg::TZ_RESET;
            fz_idx_reg  <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (cmd.accept)
        begin
            cnt_reg <= cnt_inc;
            if (ovf_now)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                if ((cnt_inc == epb_pkg::CNT_W'(1)) || (tz_c < fz_reg))
                begin
                    fz_reg     <= tz_c;
                    fz_idx_reg <= cnt_inc;
                end
                if (value[0])
                begin
                    odd_idx_reg <= cnt_inc;
                end
                if (sum_ovf)
                begin
                    total_reg <= epb_pkg::TOTAL_W'(epb_pkg::MAX_SUM);
                    ovf_reg   <= 1'b1;
                end
                else
                begin
                    total_reg <= sum_c[epb_pkg::TOTAL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            val_reg <= value;
        end
    end

    // ---------------- sweep addressing ----------------
    assign q_c    = val_reg[epb_pkg::VALUE_W-1:epb_pkg::BIT_W];
    assign r_c    = val_reg[epb_pkg::BIT_W-1:0];
    assign half_c = total_reg[epb_pkg::TOTAL_W-1:1];

    assign re_a = cmd.shift_issue || cmd.query;
    assign ra_c = cmd.query ? half_c[epb_pkg::ADDR_W+epb_pkg::BIT_W-1:epb_pkg::BIT_W]
                            : cmd.k[epb_pkg::ADDR_W-1:0];

    // source word k-1-q; below zero reads as empty
    assign re_b    = cmd.shift_issue;
    assign rb_full = epb_pkg::BADDR_W'(cmd.k) - epb_pkg::BADDR_W'(1) - epb_pkg::BADDR_W'(q_c);
    assign rb_neg  = rb_full[epb_pkg::BADDR_W-1];
    assign rb_c    = rb_full[epb_pkg::ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (s1_wr_reg)
        begin
            mem[s1_addr_reg] <= new_word;
        end
        if (re_a)
        begin
            a_data_reg <= mem[ra_c];
        end
        if (re_b)
        begin
            b_data_reg <= mem[rb_c];
        end
        if (s1_act_reg)
        begin
            bprev_reg <= b_eff;
        end
        if (cmd.shift_issue)
        begin
            s1_addr_reg <= cmd.k[epb_pkg::ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
            a_ok_reg       <= 1'b0;
            a_zero_reg     <= 1'b0;
            b_ok_reg       <= 1'b0;
            b_zero_reg     <= 1'b0;
            b_neg_reg      <= 1'b0;
            s1_act_reg     <= 1'b0;
            s1_wr_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                word_valid_reg <= '0;
            end
            else if (s1_wr_reg)
            begin
                word_valid_reg[s1_addr_reg] <= 1'b1;
            end
            if (re_a)
            begin
                a_ok_reg   <= word_valid_reg[ra_c];
                a_zero_reg <= (ra_c == '0);
            end
            if (re_b)
            begin
                b_ok_reg   <= word_valid_reg[rb_c];
                b_zero_reg <= (rb_c == '0);
                b_neg_reg  <= rb_neg;
            end
            s1_act_reg <= cmd.shift_issue;
            // first step only primes the source window
            s1_wr_reg  <= cmd.shift_issue && (cmd.k != epb_pkg::K_W'(epb_pkg::NUM_WORDS));
        end
    end

    // never-written words read as the reset image: only sum zero set
    assign a_eff = a_ok_reg ? a_data_reg : epb_pkg::WORD_W'(a_zero_reg);
    assign b_eff = b_neg_reg ? '0 : (b_ok_reg ? b_data_reg : epb_pkg::WORD_W'(b_zero_reg));

    assign pair_shift = {bprev_reg, b_eff} << r_c;
    assign new_word   = a_eff | pair_shift[2*epb_pkg::WORD_W-1:epb_pkg::WORD_W];

    // ---------------- result ----------------
    assign remove_c = !ovf_reg && !total_reg[0] && a_eff[half_c[epb_pkg::BIT_W-1:0]];
    assign index_c  = epb_pkg::INDEX_W'((odd_idx_reg != '0) ? odd_idx_reg : fz_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            remove_count <= remove_c;
            remove_index <= remove_c ? index_c : '0;
            overflow     <= ovf_reg;
        end
    end

    assign result_valid = result_valid_reg;

    `EPB_ASSERT_IMP(a_no_source_clash, s1_wr_reg && re_b && !rb_neg, rb_c != s1_addr_reg, "sweep read hit the word being written")
    `EPB_ASSERT_IMP(a_query_after_drain, cmd.query, !s1_act_reg && !s1_wr_reg, "query issued while the sweep was still writing")
    `EPB_ASSERT_NEXT(a_finish_clears, cmd.finish, (total_reg == '0) && (cnt_reg == '0) && !ovf_reg && (word_valid_reg == '0), "set state not cleared after finish")

endmodule

`default_nettype wire

/* rtl/equal_partition_breaker_unit.sv */
// Top level of the equal partition breaker: sequencer plus datapath.
// Depends on epb_pkg, epb_ctrl and epb_datapath.
//
//   channel   beat holds                              handshake
//   item      value[10:0], last                       item_valid / item_stall
//   result    remove_count, remove_index[6:0],        result_valid / result_stall
//             overflow
//
// An item that updates the reachable sums is accepted, then swept in 129
// steps over the 128 words of 64 bits (one word read, shifted, ORed and
// written back per cycle through the sum memory), then drained.
// An item at or after overflow is only accepted. The last item of a set
// adds a read of the half-total word, then result load and clear once the result register is free.
// Reset clears control state only; the sum memory needs no clearing pass,
// since per-word valid bits drop at reset and at each set end.
// A stalled result holds in its register; the next set's items are taken
// meanwhile, and only the next result load waits for it.
`default_nettype none

module equal_partition_breaker_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic [epb_pkg::VALUE_W-1:0]   value,
    input  wire logic                          last,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic                               remove_count,
    output logic [epb_pkg::INDEX_W-1:0]        remove_index,
    output logic                               overflow
);

    epb_pkg::epb_cmd_t    cmd;
    epb_pkg::epb_status_t status;

    // Sequencer: owns the item handshake and the sweep counter.
    epb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath: statistics, sum memory, shift-OR stage, result register.
    epb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .remove_count (remove_count),
        .remove_index (remove_index),
        .overflow     (overflow)
    );

endmodule

`default_nettype wire
